### rtl/dost_pkg.sv
`default_nettype none

package dost_pkg;

  // Default number of table slots.
  localparam int unsigned DEFAULT_SLOTS = 32;

  // Widths of the item fields.
  localparam int unsigned FUNC_W   = 3;
  localparam int unsigned HANDLE_W = 5;
  localparam int unsigned DEPTH_W  = 32;
  localparam int unsigned Y_W      = 16;
  localparam int unsigned STAMP_W  = 64;
  localparam int unsigned STATUS_W = 2;

  // Operation codes.
  localparam logic [FUNC_W-1:0] FUNC_INSERT    = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_REMOVE    = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_SET_DEPTH = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_SET_Y     = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_SET_VIS   = 3'd4;
  localparam logic [FUNC_W-1:0] FUNC_LIST      = 3'd5;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_BAD   = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd3;

  // One table entry as held in a slot.
  typedef struct packed {
    logic [HANDLE_W-1:0]       handle;
    logic signed [DEPTH_W-1:0] depth;
    logic signed [Y_W-1:0]     y;
    logic [STAMP_W-1:0]        stamp;
    logic                      vis;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  // What every cell does in the current cycle.
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_REMOVE,
    CELL_SET_VIS
  } cell_op_e;

  // Control broadcast to all cells.
  typedef struct packed {
    cell_op_e op;
    logic     mode;
  } cell_ctl_t;

  // Flags a cell reports to its right-hand neighbour and to the control.
  typedef struct packed {
    logic prec;   // key sorts before this occupied entry or one to its left
    logic hit;    // this occupied entry carries the key handle
    logic seen;   // the key handle sits in this slot or one to its left
    logic shown;  // occupied and visible
  } cell_stat_t;

endpackage

`default_nettype wire

### rtl/draw_order_sorted_table_unit.sv
`default_nettype none

// Sorted draw-order table. A command is taken when start is high and busy is
// low; its results leave on out_valid_o one cycle each and cannot be stalled,
// so the receiver must take every strobed result. Insert, remove, set visible
// and set depth to an unchanged value are latched on acceptance and then done
// in an execute step in which the whole row of slots shifts in place; set
// depth and set y add a place step, as the entry is first taken out and then
// placed again through the same row. For a list, a read pointer walks the
// slots one per cycle and emits each visible handle, stopping after the last
// visible one. Each result appears in the cycle after the one that produced
// it. The ordering mode is written only while the unit is idle and no command
// is offered.
module draw_order_sorted_table_unit #(
  parameter int unsigned SLOTS = dost_pkg::DEFAULT_SLOTS
) (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire                               cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire                               cfg_ordering_mode_i,
  input  wire                               start,
  output logic                              busy,
  input  wire [dost_pkg::FUNC_W-1:0]        func_i,
  input  wire [dost_pkg::HANDLE_W-1:0]      handle_i,
  input  wire signed [dost_pkg::DEPTH_W-1:0] depth_value_i,
  input  wire signed [dost_pkg::Y_W-1:0]    y_value_i,
  input  wire                               visible_value_i,
  output logic                              out_valid_o,
  output logic [dost_pkg::HANDLE_W-1:0]     out_handle_o,
  output logic [dost_pkg::STATUS_W-1:0]     status_o,
  output logic                              last_o
);
  import dost_pkg::*;

  localparam int unsigned CW = $clog2(SLOTS + 1);
  localparam int unsigned PW = $clog2(SLOTS);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_EXEC  = 2'd1;
  localparam logic [1:0] S_PLACE = 2'd2;
  localparam logic [1:0] S_LIST  = 2'd3;

  logic [1:0]          state_q, state_d;
  logic                mode_q;
  logic [CW-1:0]       count_q, count_d;
  logic [STAMP_W-1:0]  stamp_q, stamp_d;
  logic [FUNC_W-1:0]   func_q;
  entry_t              key_q, key_d;
  logic [PW-1:0]       ptr_q, ptr_d;

  logic                res_valid_q, res_valid_d;
  logic [HANDLE_W-1:0] res_handle_q, res_handle_d;
  logic [STATUS_W-1:0] res_status_q, res_status_d;
  logic                res_last_q, res_last_d;

  cell_ctl_t           ctl;
  entry_t              ent [SLOTS];
  cell_stat_t          stat [SLOTS];

  logic                accept;
  logic                hit_any;
  logic                any_shown;
  logic                shown_after;
  logic [ENTRY_W-1:0]  sel_bits;
  entry_t              sel;
  entry_t              cur;

  assign accept      = start && !busy;
  assign busy        = state_q != S_IDLE;
  assign cfg_ready_o = !busy && !start;

  // The row of slots.
  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    entry_t     left_entry;
    cell_stat_t left_stat;
    entry_t     right_entry;

    if (i == 0) begin : g_first
      assign left_entry = key_q;
      assign left_stat  = '0;
    end else begin : g_inner
      assign left_entry = ent[i-1];
      assign left_stat  = stat[i-1];
    end

    if (i == SLOTS - 1) begin : g_last
      assign right_entry = ent[i];
    end else begin : g_body
      assign right_entry = ent[i+1];
    end

    dost_cell #(
      .SLOTS (SLOTS),
      .IDX   (i)
    ) u_cell (
      .clk_i         (clk_i),
      .ctl_i         (ctl),
      .count_i       (count_q),
      .key_i         (key_q),
      .left_entry_i  (left_entry),
      .left_stat_i   (left_stat),
      .right_entry_i (right_entry),
      .entry_o       (ent[i]),
      .stat_o        (stat[i])
    );
  end

  // Matching entry, visibility summary and the list read-out.
  always_comb begin
    hit_any     = 1'b0;
    any_shown   = 1'b0;
    shown_after = 1'b0;
    sel_bits    = '0;
    for (int i = 0; i < SLOTS; i++) begin
      hit_any   = hit_any | stat[i].hit;
      any_shown = any_shown | stat[i].shown;
      sel_bits  = sel_bits | (ent[i] & {ENTRY_W{stat[i].hit}});
      if (PW'(i) > ptr_q) begin
        shown_after = shown_after | stat[i].shown;
      end
    end
    sel = entry_t'(sel_bits);
    cur = ent[ptr_q];
  end

  // Sequencer.
  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    stamp_d      = stamp_q;
    key_d        = key_q;
    ptr_d        = ptr_q;
    ctl.op       = CELL_HOLD;
    ctl.mode     = mode_q;
    res_valid_d  = 1'b0;
    res_handle_d = key_q.handle;
    res_status_d = STAT_OK;
    res_last_d   = 1'b1;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          key_d.handle = handle_i;
          key_d.depth  = depth_value_i;
          key_d.y      = y_value_i;
          key_d.stamp  = stamp_q;
          key_d.vis    = visible_value_i;
          state_d      = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d     = S_IDLE;
        res_valid_d = 1'b1;
        unique case (func_q)
          FUNC_INSERT: begin
            if (hit_any) begin
              res_status_d = STAT_BAD;
            end else if (count_q == CW'(SLOTS)) begin
              res_status_d = STAT_FULL;
            end else begin
              ctl.op  = CELL_INSERT;
              count_d = count_q + CW'(1);
              stamp_d = stamp_q + STAMP_W'(1);
            end
          end
          FUNC_REMOVE: begin
            if (!hit_any) begin
              res_status_d = STAT_BAD;
            end else begin
              ctl.op  = CELL_REMOVE;
              count_d = count_q - CW'(1);
            end
          end
          FUNC_SET_DEPTH, FUNC_SET_Y: begin
            if (!hit_any) begin
              res_status_d = STAT_BAD;
            end else if ((func_q == FUNC_SET_DEPTH) && (sel.depth == key_q.depth)) begin
              res_status_d = STAT_OK;
            end else begin
              // Take the entry out now and place it again next cycle.
              ctl.op      = CELL_REMOVE;
              count_d     = count_q - CW'(1);
              res_valid_d = 1'b0;
              state_d     = S_PLACE;
              key_d.stamp = sel.stamp;
              key_d.vis   = sel.vis;
              if (func_q == FUNC_SET_DEPTH) begin
                key_d.y = sel.y;
              end else begin
                key_d.depth = sel.depth;
              end
            end
          end
          FUNC_SET_VIS: begin
            if (!hit_any) begin
              res_status_d = STAT_BAD;
            end else begin
              ctl.op = CELL_SET_VIS;
            end
          end
          FUNC_LIST: begin
            if (!any_shown) begin
              res_status_d = STAT_EMPTY;
            end else begin
              res_valid_d = 1'b0;
              ptr_d       = '0;
              state_d     = S_LIST;
            end
          end
          default: begin
            res_status_d = STAT_OK;
          end
        endcase
      end
      S_PLACE: begin
        ctl.op      = CELL_INSERT;
        count_d     = count_q + CW'(1);
        res_valid_d = 1'b1;
        state_d     = S_IDLE;
      end
      S_LIST: begin
        // One slot per cycle; stop after the last visible one.
        ptr_d = ptr_q + PW'(1);
        if (stat[ptr_q].shown) begin
          res_valid_d  = 1'b1;
          res_handle_d = cur.handle;
          res_last_d   = !shown_after;
          if (!shown_after) begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      mode_q      <= 1'b0;
      count_q     <= '0;
      stamp_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      stamp_q     <= stamp_d;
      res_valid_q <= res_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        mode_q <= cfg_ordering_mode_i;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    key_q        <= key_d;
    ptr_q        <= ptr_d;
    res_handle_q <= res_handle_d;
    res_status_q <= res_status_d;
    res_last_q   <= res_last_d;
    if (accept) begin
      func_q <= func_i;
    end
  end

  assign out_valid_o  = res_valid_q;
  assign out_handle_o = res_handle_q;
  assign status_o     = res_status_q;
  assign last_o       = res_last_q;

endmodule

`default_nettype wire

### rtl/dost_cell.sv
`default_nettype none

module dost_cell #(
  parameter int unsigned SLOTS = dost_pkg::DEFAULT_SLOTS,
  parameter int unsigned IDX   = 0
) (
  input  wire                           clk_i,
  input  dost_pkg::cell_ctl_t           ctl_i,
  input  wire [$clog2(SLOTS+1)-1:0]     count_i,
  input  dost_pkg::entry_t              key_i,
  input  dost_pkg::entry_t              left_entry_i,
  input  dost_pkg::cell_stat_t          left_stat_i,
  input  dost_pkg::entry_t              right_entry_i,
  output dost_pkg::entry_t              entry_o,
  output dost_pkg::cell_stat_t          stat_o
);
  import dost_pkg::*;

  localparam int unsigned CW = $clog2(SLOTS + 1);

  entry_t     entry_q;
  entry_t     entry_d;
  logic       occ;
  logic       at_end;
  logic       key_first;
  cell_stat_t stat;

  // Occupancy follows from the fill count alone.
  assign occ    = CW'(IDX) < count_i;
  assign at_end = CW'(IDX) == count_i;

  // Sort order: depth, then y in mode 1, then the earlier stamp.
  always_comb begin
    if (key_i.depth != entry_q.depth) begin
      key_first = $signed(key_i.depth) < $signed(entry_q.depth);
    end else if (ctl_i.mode && (key_i.y != entry_q.y)) begin
      key_first = $signed(key_i.y) < $signed(entry_q.y);
    end else begin
      key_first = key_i.stamp < entry_q.stamp;
    end
  end

  // Flags handed on to the next cell. The precedence flag is carried along
  // the row, so only the first entry that the key precedes takes the key,
  // even when the row was sorted under the other ordering mode.
  always_comb begin
    stat.prec  = left_stat_i.prec || (occ && key_first);
    stat.hit   = occ && (entry_q.handle == key_i.handle);
    stat.seen  = left_stat_i.seen || stat.hit;
    stat.shown = occ && entry_q.vis;
  end

  assign stat_o  = stat;
  assign entry_o = entry_q;

  // Take the left entry when shifting up, the right one when closing a gap.
  always_comb begin
    entry_d = entry_q;
    unique case (ctl_i.op)
      CELL_INSERT: begin
        if (left_stat_i.prec) begin
          entry_d = left_entry_i;
        end else if (stat.prec || at_end) begin
          entry_d = key_i;
        end
      end
      CELL_REMOVE: begin
        if (stat.seen) begin
          entry_d = right_entry_i;
        end
      end
      CELL_SET_VIS: begin
        if (stat.hit) begin
          entry_d.vis = key_i.vis;
        end
      end
      default: begin
        entry_d = entry_q;
      end
    endcase
  end

  // Slot contents need no reset: the fill count says what is valid.
  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

`default_nettype wire

### rtl/dost_checker.sv
`default_nettype none

module dost_checker (
  input wire                          clk_i,
  input wire                          rst_ni,
  input wire                          start,
  input wire                          busy,
  input wire                          out_valid_o,
  input wire [dost_pkg::STATUS_W-1:0] status_o,
  input wire                          last_o
);
  import dost_pkg::*;

  // An accepted command always keeps the unit busy in the next cycle.
  a_accept_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("unit not busy after accepting a command");

  // Every result is produced by work done in the previous cycle.
  a_result_after_work : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $past(busy))
    else $error("result without preceding work");

  // Further results of a list are still pending, so the unit stays busy.
  a_more_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o |-> busy)
    else $error("unit idle while a list is unfinished");

  // Only listed handles come without the last mark, and they are all ok.
  a_not_last_ok : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o |-> status_o == STAT_OK)
    else $error("non-final result with error status");

  // An empty list is a single result.
  a_empty_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == STAT_EMPTY) |-> last_o)
    else $error("empty list result without last mark");

endmodule

bind draw_order_sorted_table_unit dost_checker u_dost_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start       (start),
  .busy        (busy),
  .out_valid_o (out_valid_o),
  .status_o    (status_o),
  .last_o      (last_o)
);

`default_nettype wire

### sim/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import dost_pkg::*;

  localparam int unsigned TABLE_SLOTS = DEFAULT_SLOTS;
  // Longest quiet spell of a correct run is a full list walk plus the
  // longest sender gap; this is many times that.
  localparam int unsigned STALL_LIMIT = 2000;

  // Function codes the block treats as no-ops.
  localparam logic [FUNC_W-1:0] FUNC_SPARE6 = 3'd6;
  localparam logic [FUNC_W-1:0] FUNC_SPARE7 = 3'd7;

  // One command as presented on the input pins, with its leading gap.
  typedef struct {
    logic [FUNC_W-1:0]   func;
    logic [HANDLE_W-1:0] hnd;
    logic [DEPTH_W-1:0]  dep;
    logic [Y_W-1:0]      ypos;
    logic                vis;
    int unsigned         gap;
  } cmd_t;

  // One result transaction.
  typedef struct packed {
    logic [HANDLE_W-1:0] hnd;
    logic [STATUS_W-1:0] status;
    logic                last;
  } reply_t;

  // One entry of the draw list.
  typedef struct packed {
    logic [HANDLE_W-1:0] hnd;
    logic [DEPTH_W-1:0]  dep;
    logic [Y_W-1:0]      ypos;
    logic [STAMP_W-1:0]  stmp;
    logic                shown;
  } slot_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic                cfg_ordering_mode_i = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  logic [FUNC_W-1:0]   func_i = '0;
  logic [HANDLE_W-1:0] handle_i = '0;
  logic [DEPTH_W-1:0]  depth_value_i = '0;
  logic [Y_W-1:0]      y_value_i = '0;
  logic                visible_value_i = 1'b0;
  logic                out_valid_o;
  logic [HANDLE_W-1:0] out_handle_o;
  logic [STATUS_W-1:0] status_o;
  logic                last_o;

  // Draw list as the block should hold it.
  slot_t               dl_slot [TABLE_SLOTS];
  int                  dl_count = 0;
  logic [STAMP_W-1:0]  dl_stamp = '0;
  logic                dl_mode = 1'b0;

  cmd_t                pending [$];
  reply_t              replies_q [$];
  cmd_t                cur_cmd;
  reply_t              head;
  int unsigned         wait_cnt = 0;
  int unsigned         quiet_cycles = 0;
  int unsigned         mismatches = 0;
  logic [31:0]         shadow = '0;
  bit                  no_gaps = 1'b0;

  draw_order_sorted_table_unit i_dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_valid_i         (cfg_valid_i),
    .cfg_ready_o         (cfg_ready_o),
    .cfg_ordering_mode_i (cfg_ordering_mode_i),
    .start               (start),
    .busy                (busy),
    .func_i              (func_i),
    .handle_i            (handle_i),
    .depth_value_i       (depth_value_i),
    .y_value_i           (y_value_i),
    .visible_value_i     (visible_value_i),
    .out_valid_o         (out_valid_o),
    .out_handle_o        (out_handle_o),
    .status_o            (status_o),
    .last_o              (last_o)
  );

  always #2 clk_i = ~clk_i;

  // Drawing order: depth, then y in the second mode, then creation stamp.
  function automatic bit sorts_before(slot_t a, slot_t b);
    if (a.dep != b.dep) return $signed(a.dep) < $signed(b.dep);
    if (dl_mode && a.ypos != b.ypos) return $signed(a.ypos) < $signed(b.ypos);
    return a.stmp < b.stmp;
  endfunction

  function automatic int find_handle(logic [HANDLE_W-1:0] h);
    for (int j = 0; j < dl_count; j++)
      if (dl_slot[j].hnd == h) return j;
    return -1;
  endfunction

  // Put an entry before the first one it precedes, or at the end.
  function automatic void slot_in(slot_t e);
    int pos;
    pos = 0;
    while (pos < dl_count && !sorts_before(e, dl_slot[pos])) pos++;
    for (int j = dl_count; j > pos; j--) dl_slot[j] = dl_slot[j-1];
    dl_slot[pos] = e;
    dl_count++;
  endfunction

  function automatic void slot_out(int idx);
    for (int j = idx; j < dl_count - 1; j++) dl_slot[j] = dl_slot[j+1];
    dl_count--;
  endfunction

  // Apply one accepted command to the draw list and queue the replies it owes.
  function automatic void exec_draw_cmd(cmd_t c);
    int     idx;
    int     nvis;
    int     k;
    slot_t  e;
    reply_t r;
    idx = find_handle(c.hnd);
    r.hnd = c.hnd;
    r.status = STAT_OK;
    r.last = 1'b1;
    case (c.func)
      FUNC_LIST: begin
        nvis = 0;
        for (int j = 0; j < dl_count; j++) if (dl_slot[j].shown) nvis++;
        if (nvis == 0) begin
          r.status = STAT_EMPTY;
          replies_q.push_back(r);
        end else begin
          k = 0;
          for (int j = 0; j < dl_count; j++) begin
            if (dl_slot[j].shown) begin
              k++;
              r.hnd = dl_slot[j].hnd;
              r.last = (k == nvis);
              replies_q.push_back(r);
            end
          end
        end
        return;
      end
      FUNC_INSERT: begin
        if (idx >= 0) r.status = STAT_BAD;
        else if (dl_count >= TABLE_SLOTS) r.status = STAT_FULL;
        else begin
          e.hnd = c.hnd;
          e.dep = c.dep;
          e.ypos = c.ypos;
          e.stmp = dl_stamp;
          e.shown = c.vis;
          slot_in(e);
          dl_stamp++;
        end
      end
      FUNC_REMOVE: begin
        if (idx < 0) r.status = STAT_BAD;
        else slot_out(idx);
      end
      FUNC_SET_DEPTH: begin
        if (idx < 0) r.status = STAT_BAD;
        else if (dl_slot[idx].dep != c.dep) begin
          e = dl_slot[idx];
          e.dep = c.dep;
          slot_out(idx);
          slot_in(e);
        end
      end
      FUNC_SET_Y: begin
        if (idx < 0) r.status = STAT_BAD;
        else begin
          e = dl_slot[idx];
          e.ypos = c.ypos;
          slot_out(idx);
          slot_in(e);
        end
      end
      FUNC_SET_VIS: begin
        if (idx < 0) r.status = STAT_BAD;
        else dl_slot[idx].shown = c.vis;
      end
      default: begin
      end
    endcase
    replies_q.push_back(r);
  endfunction

  task automatic present_cmd(cmd_t c);
    cur_cmd = c;
    func_i <= c.func;
    handle_i <= c.hnd;
    depth_value_i <= c.dep;
    y_value_i <= c.ypos;
    visible_value_i <= c.vis;
  endtask

  // Command driver: holds start until a transaction is taken, then waits the
  // next command's gap, or keeps start high straight away when it has none.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) begin
        exec_draw_cmd(cur_cmd);
        wait_cnt = 0;
        if (pending.size() != 0 && pending[0].gap == 0) begin
          present_cmd(pending.pop_front());
        end else begin
          start <= 1'b0;
        end
      end else if (!start && pending.size() != 0) begin
        if (wait_cnt >= pending[0].gap) begin
          present_cmd(pending.pop_front());
          start <= 1'b1;
          wait_cnt = 0;
        end else begin
          wait_cnt++;
        end
      end
    end
  end

  // Result monitor: every strobed result must match the oldest reply owed.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o) begin
      if (replies_q.size() == 0) begin
        $display("%0t: result with nothing owed: handle %0d status %0d last %0d",
                 $time, out_handle_o, status_o, last_o);
        mismatches++;
      end else begin
        head = replies_q.pop_front();
        if (out_handle_o !== head.hnd || status_o !== head.status || last_o !== head.last) begin
          $display("%0t: mismatch: expected handle %0d status %0d last %0d, got %0d %0d %0d",
                   $time, head.hnd, head.status, head.last, out_handle_o, status_o, last_o);
          mismatches++;
        end
      end
    end
  end

  // Watchdog on cycles in which no transaction of any kind is taken.
  always @(posedge clk_i) begin
    if ((start && !busy) || out_valid_o || (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [DEPTH_W-1:0] draw_depth();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r < 6) return DEPTH_W'($urandom_range(0, 4)) - DEPTH_W'(2);
    if (r == 6) return 32'h8000_0000;
    if (r == 7) return 32'h7fff_ffff;
    return $urandom();
  endfunction

  function automatic logic [Y_W-1:0] draw_y();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r < 8) return Y_W'($urandom_range(0, 4)) - Y_W'(2);
    if (r == 8) return 16'h8000;
    if (r == 9) return 16'h7fff;
    return Y_W'($urandom());
  endfunction

  // Handle that is (or is not) in the list as the stimulus stands so far.
  function automatic logic [HANDLE_W-1:0] pick_handle(bit want_present);
    logic [HANDLE_W-1:0] first;
    logic [HANDLE_W-1:0] h;
    first = HANDLE_W'($urandom());
    for (int k = 0; k < 32; k++) begin
      h = first + HANDLE_W'(k);
      if (shadow[h] == want_present) return h;
    end
    return first;
  endfunction

  task automatic queue_cmd(logic [FUNC_W-1:0] f, logic [HANDLE_W-1:0] h,
                           logic [DEPTH_W-1:0] d, logic [Y_W-1:0] yv, logic v);
    cmd_t c;
    if ($urandom_range(0, 11) == 0) no_gaps = !no_gaps;
    c.func = f;
    c.hnd = h;
    c.dep = d;
    c.ypos = yv;
    c.vis = v;
    c.gap = no_gaps ? 0 : $urandom_range(0, 15);
    if (f == FUNC_INSERT) shadow[h] = 1'b1;
    else if (f == FUNC_REMOVE) shadow[h] = 1'b0;
    pending.push_back(c);
  endtask

  // Mostly commands on live handles, with some listing and some noise.
  task automatic random_cmds(int n);
    int unsigned roll;
    int unsigned occ;
    int unsigned ins_pct;
    int unsigned pick;
    logic [FUNC_W-1:0] op;
    for (int i = 0; i < n; i++) begin
      roll = $urandom_range(0, 99);
      if (roll < 10) begin
        queue_cmd(FUNC_LIST, HANDLE_W'($urandom()), draw_depth(), draw_y(), 1'($urandom()));
      end else if (roll < 16) begin
        queue_cmd(FUNC_W'($urandom()), HANDLE_W'($urandom()), draw_depth(), draw_y(),
                  1'($urandom()));
      end else begin
        occ = $countones(shadow);
        ins_pct = (occ < 6) ? 70 : (occ > 26) ? 15 : 35;
        if (occ == 0 || $urandom_range(0, 99) < ins_pct) begin
          queue_cmd(FUNC_INSERT, pick_handle(1'b0), draw_depth(), draw_y(),
                    $urandom_range(0, 3) != 0);
        end else begin
          pick = $urandom_range(0, 99);
          if (pick < 15) op = FUNC_REMOVE;
          else if (pick < 45) op = FUNC_SET_DEPTH;
          else if (pick < 75) op = FUNC_SET_Y;
          else op = FUNC_SET_VIS;
          queue_cmd(op, pick_handle(1'b1), draw_depth(), draw_y(), $urandom_range(0, 3) != 0);
        end
      end
    end
  endtask

  // Wait until every command is taken and every reply has come back.
  task automatic drain();
    while (pending.size() != 0 || start || replies_q.size() != 0 || busy) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_order_mode(logic m);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_ordering_mode_i <= m;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    dl_mode = m;
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part in depth-then-stamp order: empty list, absent handles,
    // key extremes, duplicates, unchanged depth, spare codes.
    write_order_mode(1'b0);
    @(negedge clk_i);
    queue_cmd(FUNC_LIST, 5'd7, '0, '0, 1'b0);
    queue_cmd(FUNC_REMOVE, 5'd3, '0, '0, 1'b0);
    queue_cmd(FUNC_SET_DEPTH, 5'd3, 32'd9, '0, 1'b0);
    queue_cmd(FUNC_SET_Y, 5'd3, '0, 16'd9, 1'b0);
    queue_cmd(FUNC_SET_VIS, 5'd3, '0, '0, 1'b1);
    queue_cmd(FUNC_INSERT, 5'd0, 32'h7fff_ffff, 16'h7fff, 1'b1);
    queue_cmd(FUNC_INSERT, 5'd31, 32'h8000_0000, 16'h8000, 1'b1);
    queue_cmd(FUNC_INSERT, 5'd5, 32'd0, 16'd0, 1'b0);
    queue_cmd(FUNC_INSERT, 5'd6, 32'd0, 16'hfffb, 1'b1);
    queue_cmd(FUNC_INSERT, 5'd5, 32'd1, 16'd1, 1'b1);
    queue_cmd(FUNC_SET_DEPTH, 5'd6, 32'd0, '0, 1'b0);
    queue_cmd(FUNC_SET_Y, 5'd5, '0, 16'd100, 1'b0);
    queue_cmd(FUNC_SET_VIS, 5'd5, '0, '0, 1'b1);
    queue_cmd(FUNC_SPARE6, 5'd9, '0, '0, 1'b0);
    queue_cmd(FUNC_SPARE7, 5'd10, 32'hffff_ffff, 16'hffff, 1'b1);
    queue_cmd(FUNC_LIST, 5'd0, '0, '0, 1'b0);
    queue_cmd(FUNC_REMOVE, 5'd0, '0, '0, 1'b0);
    queue_cmd(FUNC_SET_DEPTH, 5'd31, 32'h7fff_ffff, '0, 1'b0);
    queue_cmd(FUNC_LIST, 5'd1, '0, '0, 1'b0);
    drain();

    // Fill the table to the last slot under y ordering, list it whole, then
    // try a further insert on the full table before mixed traffic.
    write_order_mode(1'b1);
    @(negedge clk_i);
    for (int h = 0; h < 32; h++)
      if (!shadow[h]) queue_cmd(FUNC_INSERT, HANDLE_W'(h), draw_depth(), draw_y(), 1'b1);
    queue_cmd(FUNC_LIST, 5'd2, '0, '0, 1'b0);
    queue_cmd(FUNC_INSERT, 5'd12, 32'd0, 16'd0, 1'b1);
    random_cmds(80);
    drain();

    write_order_mode(1'b0);
    @(negedge clk_i);
    random_cmds(80);
    drain();

    write_order_mode(1'b1);
    @(negedge clk_i);
    random_cmds(50);
    drain();

    if (mismatches == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
